[hdl/b32d_pkg.sv]
// Shared types, status codes and the symbol lookup of the base32 text decoder.
package b32d_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LENGTH   = 2'd1;
    localparam logic [1:0] ST_BAD_CHAR = 2'd2;
    localparam logic [1:0] ST_LEFTOVER = 2'd3;

    localparam logic [7:0] EXPECTED_RESET = 8'd32;
    localparam logic [8:0] COUNT_MAX      = 9'd511;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data_byte;
        logic       has_status;
        logic [1:0] status;
    } t_entry;

    // Returns {valid, value}; letters are folded to lower case first.
    function automatic logic [5:0] sym_lookup(input logic [7:0] c);
        logic [7:0] lc;
        logic [5:0] r;
        lc = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            lc = c + 8'h20;
        end
        r = 6'd0;
        if (lc >= 8'h30 && lc <= 8'h39) begin
            r = {1'b1, 1'b0, lc[3:0] - 4'h0};
        end else begin
            case (lc)
                8'h6F: r = {1'b1, 5'd0};
                8'h69: r = {1'b1, 5'd1};
                8'h6C: r = {1'b1, 5'd1};
                8'h62: r = {1'b1, 5'd8};
                8'h61: r = {1'b1, 5'd10};
                8'h63: r = {1'b1, 5'd11};
                8'h64: r = {1'b1, 5'd12};
                8'h65: r = {1'b1, 5'd13};
                8'h66: r = {1'b1, 5'd14};
                8'h67: r = {1'b1, 5'd15};
                8'h68: r = {1'b1, 5'd16};
                8'h6A: r = {1'b1, 5'd17};
                8'h6B: r = {1'b1, 5'd18};
                8'h6D: r = {1'b1, 5'd19};
                8'h6E: r = {1'b1, 5'd20};
                8'h70: r = {1'b1, 5'd21};
                8'h71: r = {1'b1, 5'd22};
                8'h72: r = {1'b1, 5'd23};
                8'h73: r = {1'b1, 5'd24};
                8'h74: r = {1'b1, 5'd25};
                8'h75: r = {1'b1, 5'd26};
                8'h76: r = {1'b1, 5'd27};
                8'h77: r = {1'b1, 5'd28};
                8'h78: r = {1'b1, 5'd29};
                8'h79: r = {1'b1, 5'd30};
                8'h7A: r = {1'b1, 5'd31};
                default: r = 6'd0;
            endcase
        end
        return r;
    endfunction

endpackage

[hdl/b32d_front.sv]
// Front end: accepts characters, decodes symbols, assembles bytes and builds queue entries.
module b32d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_char_code,
    input  logic              i_last,
    input  logic              i_room,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    output logic              o_ready,
    output logic              o_push,
    output b32d_pkg::t_entry  o_entry
);
    import b32d_pkg::*;

    logic [6:0] r_bit_buffer;
    logic [3:0] r_bit_count;
    logic [8:0] r_byte_count;
    logic       r_bad_seen;
    logic [7:0] r_expected;

    logic [6:0] n_bit_buffer;
    logic [3:0] n_bit_count;
    logic [8:0] n_byte_count;
    logic       n_bad_seen;

    logic [5:0]  sym;
    logic [11:0] shifted;
    logic [3:0]  count_plus;
    logic [2:0]  rem;
    logic [6:0]  rem_mask;
    logic [11:0] byte_shift;
    logic        byte_done;
    logic        accept;
    logic [1:0]  status;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;

    always_comb begin
        sym        = sym_lookup(i_char_code);
        shifted    = {r_bit_buffer[6:0], sym[4:0]};
        count_plus = r_bit_count + 4'd5;
        rem        = 3'(count_plus - 4'd8);
        rem_mask   = 7'((8'd1 << rem) - 8'd1);
        byte_shift = shifted >> rem;
        byte_done  = sym[5] && (count_plus >= 4'd8);

        n_bit_buffer = r_bit_buffer;
        n_bit_count  = r_bit_count;
        n_byte_count = r_byte_count;
        n_bad_seen   = r_bad_seen;
        if (!sym[5]) begin
            n_bad_seen = 1'b1;
        end else if (byte_done) begin
            n_bit_buffer = shifted[6:0] & rem_mask;
            n_bit_count  = {1'b0, rem};
            if (r_byte_count != COUNT_MAX) begin
                n_byte_count = r_byte_count + 9'd1;
            end
        end else begin
            n_bit_buffer = shifted[6:0];
            n_bit_count  = count_plus;
        end

        if (n_byte_count != {1'b0, r_expected}) begin
            status = ST_LENGTH;
        end else if (n_bad_seen) begin
            status = ST_BAD_CHAR;
        end else if (n_bit_buffer != 7'd0) begin
            status = ST_LEFTOVER;
        end else begin
            status = ST_OK;
        end

        o_entry.has_data   = byte_done && !r_bad_seen;
        o_entry.data_byte  = byte_shift[7:0];
        o_entry.has_status = i_last;
        o_entry.status     = status;
        o_push             = accept && (o_entry.has_data || i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_buffer <= '0;
            r_bit_count  <= '0;
            r_byte_count <= '0;
            r_bad_seen   <= 1'b0;
            r_expected   <= EXPECTED_RESET;
        end else begin
            if (i_cfg_we) begin
                r_expected <= i_cfg_wdata;
            end
            if (accept) begin
                if (i_last) begin
                    r_bit_buffer <= '0;
                    r_bit_count  <= '0;
                    r_byte_count <= '0;
                    r_bad_seen   <= 1'b0;
                end else begin
                    r_bit_buffer <= n_bit_buffer;
                    r_bit_count  <= n_bit_count;
                    r_byte_count <= n_byte_count;
                    r_bad_seen   <= n_bad_seen;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count < 4'd8)
        else $error("pending bit count out of range");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last |=> r_byte_count == 9'd0 && r_bit_count == 4'd0 && !r_bad_seen)
        else $error("string state not cleared after last character");
`endif

endmodule

[hdl/b32d_fifo.sv]
// Short queue of result entries between the front and back ends.
module b32d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b32d_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_empty,
    output b32d_pkg::t_entry  o_head
);
    import b32d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry         r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_room  = r_count != CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'(DEPTH) |-> !i_push)
        else $error("queue written while full");
`endif

endmodule

[hdl/b32d_back.sv]
// Back end: expands queue entries into data and status items in the output register.
module b32d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  b32d_pkg::t_entry  i_head,
    input  logic              i_ready,
    output logic              o_pop,
    output logic              o_valid,
    output logic [7:0]        o_data_byte,
    output logic              o_is_status,
    output logic [1:0]        o_status,
    output logic              o_end_mark
);
    import b32d_pkg::*;

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_is_status;
    logic [1:0] r_status;
    logic       r_sub;
    logic       load;
    logic       take_data;

    assign load      = (!r_valid || i_ready) && !i_empty;
    assign take_data = i_head.has_data && !r_sub;
    assign o_pop     = load && (!take_data || !i_head.has_status);

    assign o_valid     = r_valid;
    assign o_data_byte = r_data_byte;
    assign o_is_status = r_is_status;
    assign o_status    = r_status;
    assign o_end_mark  = r_is_status;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data_byte <= take_data ? i_head.data_byte : 8'd0;
            r_is_status <= !take_data;
            r_status    <= take_data ? ST_OK : i_head.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= take_data && i_head.has_status;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_sub_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> !i_empty && i_head.has_status)
        else $error("status half pending without a queued entry");
`endif

endmodule

[hdl/base32_text_decoder.sv]
// Top level of the base32 text decoder.
//
// The input stream carries one text character per item in s_axis tdata, with
// tlast on the final character of a string. Each valid character adds five bits;
// whenever eight bits are ready a data item goes out on m_axis. The last
// character also produces a status item (tuser high, tlast high) that reports
// length mismatch, invalid character or nonzero leftover bits. Data items are
// suppressed after an invalid character in the same string.
// The character stream is taken at one item per cycle while the queue has room. A
// result passes through the queue and then the output register: its entry is
// written into the queue at the accepting edge and moves into the output register
// once that register is free. A final character that also completes a byte
// yields a data item and then a status item; the queue of QUEUE_DEPTH entries
// absorbs that, and tready drops only when the queue is full.
// When the receiver stalls, the output register holds and the queue fills, then
// the input side stalls. Reset clears the string state and the queue and sets
// the expected length to 32; the length register is written with i_cfg_we, which
// the user must assert only while the block is idle; the block does not enforce it.
module base32_text_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // char_code[7:0]
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // data_byte[7:0], status[9:8], zero[15:10]
    output logic        o_m_axis_tuser,   // is_status[0]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);
    import b32d_pkg::*;

    logic       room;
    logic       push;
    logic       pop;
    logic       empty;
    t_entry     entry;
    t_entry     head;
    logic [7:0] data_byte;
    logic [1:0] status;

    b32d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_char_code (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_room      (room),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ready     (o_s_axis_tready),
        .o_push      (push),
        .o_entry     (entry)
    );

    b32d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_room  (room),
        .o_empty (empty),
        .o_head  (head)
    );

    b32d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .i_ready     (i_m_axis_tready),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .o_data_byte (data_byte),
        .o_is_status (o_m_axis_tuser),
        .o_status    (status),
        .o_end_mark  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'd0, status, data_byte};

endmodule

[test/b32d_checker.sv]
// Checker that predicts the decoder's result items from its input items and compares them.
module b32d_checker
    import b32d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_char,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    input  logic        i_out_user,
    input  logic        i_out_last,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8*32-1:0] SYMBOLS = "0123456789acdefghjkmnpqrstuvwxyz";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_status;
        logic [1:0] status;
        logic       end_mark;
    } t_decoded;

    t_decoded   expected_items[$];
    logic [11:0] bit_pool;
    logic [3:0]  pool_bits;
    logic [8:0]  bytes_decoded;
    logic        bad_seen;
    logic [7:0]  length_reg;
    int          fails = 0;

    function automatic logic [5:0] symbol_of(input logic [7:0] c);
        logic [7:0] lower;
        lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (lower == "o") return {1'b1, 5'd0};
        if (lower == "i" || lower == "l") return {1'b1, 5'd1};
        if (lower == "b") return {1'b1, 5'd8};
        for (int k = 0; k < 32; k++) begin
            if (SYMBOLS[8*(31-k) +: 8] == lower) return {1'b1, 5'(k)};
        end
        return 6'd0;
    endfunction

    task automatic decode_char(input logic [7:0] c, input logic is_last);
        logic [5:0] sym;
        logic [7:0] one_byte;
        t_decoded   item;
        sym = symbol_of(c);
        if (!sym[5]) begin
            bad_seen = 1'b1;
        end else begin
            bit_pool = {bit_pool[6:0], sym[4:0]};
            pool_bits = pool_bits + 4'd5;
            if (pool_bits >= 4'd8) begin
                pool_bits = pool_bits - 4'd8;
                one_byte = 8'(bit_pool >> pool_bits);
                bit_pool = bit_pool & ((12'd1 << pool_bits) - 12'd1);
                if (bytes_decoded != COUNT_MAX) bytes_decoded = bytes_decoded + 9'd1;
                if (!bad_seen) begin
                    item = '{data_byte: one_byte, is_status: 1'b0, status: ST_OK,
                             end_mark: 1'b0};
                    expected_items.push_back(item);
                end
            end
        end
        if (is_last) begin
            item = '{data_byte: 8'd0, is_status: 1'b1, status: ST_OK, end_mark: 1'b1};
            if (bytes_decoded != {1'b0, length_reg}) item.status = ST_LENGTH;
            else if (bad_seen) item.status = ST_BAD_CHAR;
            else if (bit_pool != 12'd0) item.status = ST_LEFTOVER;
            expected_items.push_back(item);
            bit_pool = '0;
            pool_bits = '0;
            bytes_decoded = '0;
            bad_seen = 1'b0;
        end
    endtask

    // Items are shown packed as {data_byte, is_status, status, end_mark}.
    always @(posedge i_clk) begin
        t_decoded want;
        t_decoded got;
        if (!i_rst_n) begin
            bit_pool = '0;
            pool_bits = '0;
            bytes_decoded = '0;
            bad_seen = 1'b0;
            length_reg = EXPECTED_RESET;
            expected_items.delete();
            o_pending <= 0;
            o_fail_count <= fails;
        end else begin
            if (i_cfg_we) begin
                length_reg = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                got = '{data_byte: i_out_data[7:0], is_status: i_out_user,
                        status: i_out_data[9:8], end_mark: i_out_last};
                if (expected_items.size() == 0) begin
                    fails++;
                    $display("%0t: expected no item, got %03h", $time, got);
                end else begin
                    want = expected_items.pop_front();
                    if (got != want || i_out_data[15:10] != 6'd0) begin
                        fails++;
                        $display("%0t: expected %03h, got %03h pad %02h",
                                 $time, want, got, i_out_data[15:10]);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_char(i_in_char, i_in_last);
            end
            o_pending <= expected_items.size();
            o_fail_count <= fails;
        end
    end

endmodule

[test/testbench.sv]
// Top of the decoder testbench: clock, reset, character stimulus, receiver stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8*32-1:0] SYMBOLS = "0123456789acdefghjkmnpqrstuvwxyz";
    localparam int QUIET_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    int          fail_count;
    int          pending;
    int          chars_sent = 0;
    bit          src_idle = 1'b0;
    bit          sink_idle = 1'b0;
    int          text_len = 32;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    base32_text_decoder DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    b32d_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_char    (s_tdata),
        .i_in_last    (s_tlast),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_user   (m_tuser),
        .i_out_last   (m_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic bit is_symbol(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [7:0] spell_symbol(input logic [4:0] v);
        logic [7:0] c;
        c = SYMBOLS[8*(31-v) +: 8];
        case (v)
            5'd0: c = ($urandom_range(0, 2) == 0) ? "0" : ($urandom_range(0, 1) ? "o" : "O");
            5'd1: begin
                case ($urandom_range(0, 4))
                    0: c = "1";
                    1: c = "i";
                    2: c = "I";
                    3: c = "l";
                    default: c = "L";
                endcase
            end
            5'd8: c = ($urandom_range(0, 2) == 0) ? "8" : ($urandom_range(0, 1) ? "b" : "B");
            default: begin
                if (v >= 5'd10 && $urandom_range(0, 1)) c = c - 8'd32;
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_symbol(c));
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k], k == s.len() - 1);
        end
    endtask

    // bad_pos selects where an invalid character goes in; a value equal to the
    // symbol count puts it last, and a negative value leaves the string clean.
    task automatic send_string(input int n_bytes, input bit clean_tail, input int bad_pos);
        int n_syms;
        int spare;
        logic [4:0] v;
        n_syms = (8 * n_bytes + 4) / 5;
        if (n_syms == 0) n_syms = 1;
        spare = 5 * n_syms - 8 * n_bytes;
        for (int k = 0; k < n_syms; k++) begin
            v = 5'($urandom_range(0, 31));
            if (k == n_syms - 1) begin
                if (clean_tail) v = v & ~5'((1 << spare) - 1);
                else if (spare > 0) v = v | 5'd1;
            end
            if (k == bad_pos) send_char(junk_char(), 1'b0);
            send_char(spell_symbol(v), k == n_syms - 1 && bad_pos != n_syms);
        end
        if (bad_pos == n_syms) send_char(junk_char(), 1'b1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_length(input logic [7:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        text_len = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int forced_len);
        int n_strings;
        int n_syms;
        int noise_len;
        set_length(8'(forced_len >= 0 ? forced_len
                      : ($urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 12))));
        src_idle = $urandom_range(0, 3) != 0;
        sink_idle = $urandom_range(0, 3) != 0;
        n_strings = $urandom_range(3, 8);
        for (int k = 0; k < n_strings; k++) begin
            n_syms = (8 * text_len + 4) / 5;
            case ($urandom_range(0, 9))
                6: send_string($urandom_range(0, text_len + 3), 1'b1, -1);
                7: send_string(text_len, 1'b1, $urandom_range(0, n_syms));
                8: send_string(text_len, 1'b0, -1);
                9: begin
                    noise_len = $urandom_range(1, 6);
                    for (int j = 0; j < noise_len; j++) begin
                        send_char(8'($urandom_range(0, 255)), j == noise_len - 1);
                    end
                end
                default: send_string(text_len, 1'b1, -1);
            endcase
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'd0;
        s_tlast <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 8'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_text("zZyYxXwW");
        set_length(8'd5);
        send_text("oOiIlLbB");
        send_char("1", 1'b0);
        send_char("2", 1'b0);
        send_char(8'h00, 1'b0);
        send_char("3", 1'b0);
        send_char("4", 1'b0);
        send_char("5", 1'b0);
        send_char("6", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("7", 1'b0);
        send_char("9", 1'b1);

        random_phase(0);
        while (chars_sent < 260) random_phase(-1);

        set_length(8'd255);
        src_idle = 1'b1;
        sink_idle = 1'b1;
        send_string(255, 1'b1, -1);
        random_phase(-1);

        drain();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        int gap;
        m_tready <= 1'b0;
        wait (rst_n);
        forever begin
            gap = sink_idle ? $urandom_range(0, 18) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
